>>> hw/rtl/sha256_message_hasher_top_macros.svh
// assertion macros for the sha-256 message hasher
// no dependencies; taken in by the top level
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/sha256_pkg.sv
// shared types, constants and round functions of the sha-256 hasher
// no dependencies
package sha256_pkg;

  localparam int unsigned BlkBits = 512;
  localparam logic [63:0] MaxBits = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;
  localparam logic [5:0]  LastPos = 6'd63;

  typedef struct packed {
    logic [BlkBits-1:0] data;
    logic               last;
    logic               err;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {F_IDLE, F_PAD} fstate_t;
  typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} bstate_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] v;
    case (t)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/sha256_if.sv
// channel interfaces of the sha-256 hasher: message bytes in, digest words out
// no dependencies
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  logic        length_error;
  modport source (output valid, digest_word, word_number, final_word, length_error,
                  input ready);
  modport sink (input valid, digest_word, word_number, final_word, length_error,
                output ready);
endinterface

>>> hw/rtl/sha256_front.sv
// front end: packs message bytes into 512-bit blocks, pads at message end
// depends on sha256_pkg and sha256_in_if
module sha256_front (
  input  logic                clk,
  input  logic                rst,
  sha256_in_if.sink           msg,
  input  sha256_pkg::q_stat_t q_stat,
  output logic                push,
  output sha256_pkg::blk_t    push_blk
);

  sha256_pkg::fstate_t state, state_next;
  logic [sha256_pkg::BlkBits-1:0] sbuf;
  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic        ovf;
  logic [63:0] len_q;
  logic        err_q;
  logic        pad_first;
  logic        extra;

  logic        fire;
  logic        shift_en;
  logic [7:0]  byte_val;
  logic        wide_pad;
  logic        last_blk;
  logic [63:0] bc_after;
  logic        ovf_after;

  assign fire = msg.valid && msg.ready;
  // 0x80 landing in the length field forces one more block
  assign wide_pad = pad_first && (pos >= sha256_pkg::LenPos);
  assign bc_after = (fire && msg.byte_present) ? bit_count + 64'd8 : bit_count;
  assign ovf_after = ovf || (fire && msg.byte_present && bit_count == sha256_pkg::MaxBits);

  always_comb begin
    state_next = state;
    msg.ready  = 1'b0;
    shift_en   = 1'b0;
    byte_val   = msg.data_byte;
    last_blk   = 1'b0;
    case (state)
      sha256_pkg::F_IDLE: begin
        msg.ready = !q_stat.full;
        shift_en  = fire && msg.byte_present;
        if (fire && msg.message_end) state_next = sha256_pkg::F_PAD;
      end
      sha256_pkg::F_PAD: begin
        shift_en = !(pos == sha256_pkg::LastPos && q_stat.full);
        if (pad_first) begin
          byte_val = sha256_pkg::PadMark;
        end else if (pos >= sha256_pkg::LenPos && !extra) begin
          byte_val = len_q[{~pos[2:0], 3'b000} +: 8];
        end else begin
          byte_val = 8'h00;
        end
        last_blk = shift_en && pos == sha256_pkg::LastPos && !(extra || wide_pad);
        if (last_blk) state_next = sha256_pkg::F_IDLE;
      end
      default: state_next = sha256_pkg::F_IDLE;
    endcase
  end

  assign push = shift_en && pos == sha256_pkg::LastPos;
  assign push_blk.data = {sbuf[sha256_pkg::BlkBits-9:0], byte_val};
  assign push_blk.last = last_blk;
  assign push_blk.err  = err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bit_count <= '0;
      ovf       <= 1'b0;
      pad_first <= 1'b0;
      extra     <= 1'b0;
    end else begin
      if (shift_en) pos <= pos + 6'd1;
      if (state == sha256_pkg::F_IDLE) begin
        bit_count <= bc_after;
        ovf       <= ovf_after;
        if (fire && msg.message_end) pad_first <= 1'b1;
      end else if (shift_en) begin
        pad_first <= 1'b0;
        if (push) begin
          extra <= 1'b0;
        end else if (wide_pad) begin
          extra <= 1'b1;
        end
        if (last_blk) begin
          bit_count <= '0;
          ovf       <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) sbuf <= push_blk.data;
    if (state == sha256_pkg::F_IDLE && fire && msg.message_end) begin
      len_q <= bc_after;
      err_q <= ovf_after;
    end
  end

endmodule

>>> hw/rtl/sha256_queue.sv
// short block queue between the front end and the compression core
// depends on sha256_pkg
module sha256_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sha256_pkg::blk_t    push_blk,
  input  logic                pop,
  output sha256_pkg::blk_t    head,
  output sha256_pkg::q_stat_t q_stat
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);

  sha256_pkg::blk_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == CntW'(DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_blk;
  end

endmodule

>>> hw/rtl/sha256_core.sv
// back end: 64-round compression, one round a cycle, then digest word output
// depends on sha256_pkg and sha256_out_if
module sha256_core (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::q_stat_t q_stat,
  input  sha256_pkg::blk_t    head,
  output logic                pop,
  sha256_out_if.source        dig
);

  sha256_pkg::bstate_t state, state_next;
  logic [31:0] hw  [8];
  logic [31:0] wk  [8];
  logic [31:0] ws  [16];
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic        last_q;
  logic        err_q;

  logic [31:0] t1, t2, w_new;

  assign t1 = wk[7] + sha256_pkg::bsig1(wk[4]) + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6]))
            + sha256_pkg::round_k(rnd) + ws[0];
  assign t2 = sha256_pkg::bsig0(wk[0]) + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
  assign w_new = sha256_pkg::ssig1(ws[14]) + ws[9] + sha256_pkg::ssig0(ws[1]) + ws[0];

  assign dig.digest_word  = hw[idx];
  assign dig.word_number  = idx;
  assign dig.final_word   = idx == 3'd7;
  assign dig.length_error = err_q;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    dig.valid  = 1'b0;
    case (state)
      sha256_pkg::B_IDLE: begin
        pop = !q_stat.empty;
        if (pop) state_next = sha256_pkg::B_ROUND;
      end
      sha256_pkg::B_ROUND: begin
        if (rnd == 6'd63) state_next = sha256_pkg::B_ADD;
      end
      sha256_pkg::B_ADD: begin
        state_next = last_q ? sha256_pkg::B_OUT : sha256_pkg::B_IDLE;
      end
      sha256_pkg::B_OUT: begin
        dig.valid = 1'b1;
        if (dig.ready && idx == 3'd7) state_next = sha256_pkg::B_IDLE;
      end
      default: state_next = sha256_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
      idx <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= sha256_pkg::init_h(3'(i));
    end else begin
      case (state)
        sha256_pkg::B_IDLE: begin
          rnd <= '0;
          idx <= '0;
        end
        sha256_pkg::B_ROUND: rnd <= rnd + 6'd1;
        sha256_pkg::B_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + wk[i];
        end
        sha256_pkg::B_OUT: begin
          if (dig.ready) begin
            idx <= idx + 3'd1;
            // digest taken, chaining value back to its initial form
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hw[i] <= sha256_pkg::init_h(3'(i));
            end
          end
        end
        default: rnd <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_q <= head.last;
      err_q  <= head.err;
      for (int i = 0; i < 8; i++) wk[i] <= hw[i];
      for (int i = 0; i < 16; i++) ws[i] <= head.data[sha256_pkg::BlkBits-1-32*i -: 32];
    end else if (state == sha256_pkg::B_ROUND) begin
      wk[7] <= wk[6];
      wk[6] <= wk[5];
      wk[5] <= wk[4];
      wk[4] <= wk[3] + t1;
      wk[3] <= wk[2];
      wk[2] <= wk[1];
      wk[1] <= wk[0];
      wk[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) ws[i] <= ws[i+1];
      ws[15] <= w_new;
    end
  end

endmodule

>>> hw/rtl/sha256_message_hasher_top.sv
// top level of the sha-256 message hasher: front end, block queue, compression core
// depends on sha256_pkg, sha256_if, sha256_front, sha256_queue, sha256_core
//
// channel | dir | payload                                             | beat
// msg     | in  | data_byte, byte_present, message_end                | one message byte
// dig     | out | digest_word, word_number, final_word, length_error  | one digest word
//
// bytes are taken one a cycle while the block queue has room and no padding is under way; a full block is
// handed over on its 64th byte. per block the core steps through one load,
// 64 rounds (one round unit, one round a cycle) and one chaining add.
// a message end adds 9 to 72 padding bytes in the front end (rest of the block,
// plus a whole block when the length no longer fits), then eight digest beats follow.
// reset is synchronous and needs no clearing pass.
// a stalled digest beat holds the core; the front end keeps filling the queue.
`include "sha256_message_hasher_top_macros.svh"
module sha256_message_hasher_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic          clk,
  input logic          rst,
  sha256_in_if.sink    msg,
  sha256_out_if.source dig
);

  logic                push, pop;
  sha256_pkg::blk_t    push_blk, head;
  sha256_pkg::q_stat_t q_stat;

  // byte packing and padding
  sha256_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg),
    .q_stat   (q_stat),
    .push     (push),
    .push_blk (push_blk)
  );

  // decouples the front end from the round engine
  sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // compression rounds and digest output
  sha256_core u_core (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .dig    (dig)
  );

  // a block is never handed to a full queue unless a block leaves it in the same cycle
  `SHA_ASSERT_IMPL(a_no_push_full, clk, rst, push, !q_stat.full || pop)
  // a byte is only taken with room in the queue
  `SHA_ASSERT_IMPL(a_take_room, clk, rst, msg.valid && msg.ready, !q_stat.full)
  // the digest ends after its eighth beat
  `SHA_ASSERT_NEXT(a_digest_end, clk, rst, dig.valid && dig.ready && dig.final_word, !dig.valid)

endmodule
